### src/iee_pkg.sv
// Package: codes, widths and precedence table for the expression evaluator.
package iee_pkg;
  localparam int StackDepth = 16;
  localparam int ValueWidth = 32;
  localparam int PtrW       = $clog2(StackDepth);
  localparam int CntW       = $clog2(StackDepth + 1);

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpLp  = 3'd4;
  localparam logic [2:0] OpRp  = 3'd5;
  localparam logic [2:0] OpEnd = 3'd6;

  localparam logic [1:0] RelLt   = 2'd0;
  localparam logic [1:0] RelGt   = 2'd1;
  localparam logic [1:0] RelEq   = 2'd2;
  localparam logic [1:0] RelNone = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StDiv0     = 2'd1;
  localparam logic [1:0] StSyntax   = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  typedef logic [ValueWidth-1:0] value_t;

  // Map a byte to an operator code; valid flag low for operands.
  function automatic logic [3:0] op_code(input logic [7:0] ch);
    case (ch)
      8'h2b:   op_code = {1'b1, OpAdd};
      8'h2d:   op_code = {1'b1, OpSub};
      8'h2a:   op_code = {1'b1, OpMul};
      8'h2f:   op_code = {1'b1, OpDiv};
      8'h28:   op_code = {1'b1, OpLp};
      8'h29:   op_code = {1'b1, OpRp};
      8'h23:   op_code = {1'b1, OpEnd};
      default: op_code = 4'd0;
    endcase
  endfunction

  // Rows: operator on top of stack; columns: incoming operator.
  function automatic logic [1:0] rel(input logic [2:0] top, input logic [2:0] inc);
    logic [1:0] r;
    r = RelNone;
    case (top)
      OpAdd, OpSub: r = (inc == OpMul || inc == OpDiv || inc == OpLp) ? RelLt : RelGt;
      OpMul, OpDiv: r = (inc == OpLp) ? RelLt : RelGt;
      OpLp: begin
        if (inc == OpRp) r = RelEq;
        else if (inc == OpEnd) r = RelNone;
        else r = RelLt;
      end
      OpRp: begin
        if (inc == OpLp) r = RelNone;
        else if (inc == OpRp || inc == OpEnd) r = RelGt;
        else r = RelLt;
      end
      OpEnd: begin
        if (inc == OpRp) r = RelNone;
        else if (inc == OpEnd) r = RelEq;
        else r = RelLt;
      end
      default: r = RelNone;
    endcase
    return r;
  endfunction
endpackage

### src/iee_if.sv
// Interfaces: valid/ready channels for input characters and results.
interface iee_char_if (input logic clk_i);
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface iee_res_if (input logic clk_i);
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

### src/iee_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module iee_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

### src/iee_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module iee_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  iee_pkg::value_t  a_i,
  input  iee_pkg::value_t  b_i,
  output logic             done_o,
  output iee_pkg::value_t  q_o
);
  import iee_pkg::*;

  localparam int BitW = $clog2(ValueWidth + 1);

  logic            busy_q;
  logic [BitW-1:0] cnt_q;
  value_t          rem_q, quo_q, den_q;
  logic            neg_q;
  logic [ValueWidth:0] trial;

  assign trial = {rem_q, quo_q[ValueWidth-1]} - {1'b0, den_q};
  assign q_o   = neg_q ? (~quo_q + 1'b1) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= BitW'(ValueWidth);
        rem_q  <= '0;
        quo_q  <= a_i[ValueWidth-1] ? (~a_i + 1'b1) : a_i;
        den_q  <= b_i[ValueWidth-1] ? (~b_i + 1'b1) : b_i;
        neg_q  <= a_i[ValueWidth-1] ^ b_i[ValueWidth-1];
      end else if (busy_q) begin
        // shift one dividend bit in, subtract where it fits
        if (!trial[ValueWidth]) rem_q <= trial[ValueWidth-1:0];
        else rem_q <= {rem_q[ValueWidth-2:0], quo_q[ValueWidth-1]};
        quo_q <= {quo_q[ValueWidth-2:0], ~trial[ValueWidth]};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == BitW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
endmodule

### src/infix_expression_evaluator_top.sv
// Top level: infix expression evaluator over two stacks held in RAM.
// An operand is pushed straight from the idle state; an operator passes a
// decision step and, for each reduction, reads both operands from the value
// stack, executes and writes back, waiting on the serial divider for a division.
// The terminator also loads the result register, waiting while the previous
// result is still held. A new character is accepted only in the idle state.
// Reset: asynchronous, active low; the stacks are empty with the terminator
// at the bottom of the operator stack. No clearing pass is needed.
module infix_expression_evaluator_top (
  input logic clk_i,
  input logic rst_ni,
  iee_char_if.sink  in_ch,
  iee_res_if.source out_ch
);
  import iee_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_RD_B, S_RD_A, S_EXEC, S_DIV, S_WB, S_END, S_OUT
  } state_e;

  state_e         state_q;
  logic [2:0]     code_q;
  logic           is_end_q;
  logic [CntW-1:0] optop_q, vtop_q;
  logic [1:0]     err_q;
  value_t         b_q, a_q, res_q;
  logic [2:0]     redop_q;

  // operator stack: bottom entry is implicit terminator held outside the RAM read path
  logic           op_we;
  logic [PtrW-1:0] op_waddr, op_raddr;
  logic [2:0]     op_wdata, op_rdata;
  logic           v_we;
  logic [PtrW-1:0] v_waddr, v_raddr;
  value_t         v_wdata, v_rdata;

  logic           div_start, div_done;
  value_t         div_q;

  iee_ram #(.Width(3), .Depth(StackDepth)) u_op_ram (
    .clk_i, .we_i(op_we), .waddr_i(op_waddr), .wdata_i(op_wdata),
    .raddr_i(op_raddr), .rdata_o(op_rdata));

  iee_ram #(.Width(ValueWidth), .Depth(StackDepth)) u_val_ram (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata));

  // the left operand arrives from the RAM in the cycle the divider starts
  iee_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(v_rdata), .b_i(b_q),
    .done_o(div_done), .q_o(div_q));

  logic [3:0] in_code;
  logic [2:0] top_op;
  logic [1:0] rel_now;

  assign in_code  = op_code(in_ch.char_in);
  assign in_ch.ready = (state_q == S_IDLE);
  // entry 0 always reads as terminator; the RAM supplies the rest
  assign top_op  = (optop_q <= CntW'(1)) ? OpEnd : op_rdata;
  assign rel_now = rel(top_op, code_q);

  // during write-back, fetch the entry that becomes the new top
  assign op_raddr = (state_q == S_WB) ? PtrW'(optop_q - 2'd2) : PtrW'(optop_q - 1'b1);
  assign v_raddr  = (state_q == S_RD_B || state_q == S_IDLE || state_q == S_DECIDE)
                    ? PtrW'(vtop_q - 1'b1) : PtrW'(vtop_q - 2'd2);

  always_comb begin
    op_we    = 1'b0;
    op_waddr = PtrW'(optop_q);
    op_wdata = code_q;
    v_we     = 1'b0;
    v_waddr  = PtrW'(vtop_q);
    v_wdata  = value_t'({{(ValueWidth-8){1'b0}}, in_ch.char_in}) - value_t'(48);
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_ch.valid && !in_code[3] && err_q == StOk && vtop_q < CntW'(StackDepth))
          v_we = 1'b1;
      end
      S_DECIDE: begin
        if (err_q == StOk && rel_now == RelLt && optop_q < CntW'(StackDepth))
          op_we = 1'b1;
      end
      S_EXEC: begin
        div_start = (redop_q == OpDiv) && (b_q != '0);
      end
      S_WB: begin
        v_we    = 1'b1;
        v_waddr = PtrW'(vtop_q - 2'd2);
        v_wdata = res_q;
      end
      default: v_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      optop_q      <= CntW'(1);
      vtop_q       <= '0;
      err_q        <= StOk;
      out_ch.valid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one is loaded this cycle
      if (out_ch.valid && out_ch.ready && state_q != S_OUT) out_ch.valid <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (!in_code[3]) begin
              // operand: push, or flag overflow
              if (err_q == StOk) begin
                if (vtop_q < CntW'(StackDepth)) vtop_q <= vtop_q + 1'b1;
                else err_q <= StOverflow;
              end
            end else begin
              code_q   <= in_code[2:0];
              is_end_q <= (in_code[2:0] == OpEnd);
              state_q  <= (err_q == StOk) ? S_DECIDE : S_END;
            end
          end
        end
        S_DECIDE: begin
          case (rel_now)
            RelGt: begin
              redop_q <= top_op;
              if (vtop_q < CntW'(2)) begin
                err_q   <= StSyntax;
                state_q <= S_END;
              end else state_q <= S_RD_B;
            end
            RelLt: begin
              if (optop_q < CntW'(StackDepth)) optop_q <= optop_q + 1'b1;
              else err_q <= StOverflow;
              state_q <= S_END;
            end
            RelEq: begin
              if (code_q != OpEnd) optop_q <= optop_q - 1'b1;
              state_q <= S_END;
            end
            default: begin
              err_q   <= StSyntax;
              state_q <= S_END;
            end
          endcase
        end
        S_RD_B: state_q <= S_RD_A;
        S_RD_A: begin
          b_q     <= v_rdata;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          a_q <= v_rdata;
          state_q <= S_DIV;
        end
        S_DIV: begin
          // operands now in a_q, b_q
          case (redop_q)
            OpAdd: begin res_q <= a_q + b_q; state_q <= S_WB; end
            OpSub: begin res_q <= a_q - b_q; state_q <= S_WB; end
            OpMul: begin res_q <= a_q * b_q; state_q <= S_WB; end
            OpDiv: begin
              if (b_q == '0) begin
                res_q   <= '0;
                err_q   <= StDiv0;
                state_q <= S_WB;
              end else if (div_done) begin
                res_q   <= div_q;
                state_q <= S_WB;
              end
            end
            default: begin
              res_q   <= '0;
              err_q   <= StSyntax;
              state_q <= S_WB;
            end
          endcase
        end
        S_WB: begin
          vtop_q  <= vtop_q - 1'b1;
          optop_q <= optop_q - 1'b1;
          state_q <= (err_q == StOk) ? S_DECIDE : S_END;
        end
        S_END: begin
          state_q <= is_end_q ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          // hold until the previous result has gone
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            if (err_q == StOk && vtop_q == CntW'(1)) begin
              out_ch.result_value <= 32'(signed'(res_q));
              out_ch.status       <= StOk;
            end else begin
              out_ch.result_value <= '0;
              out_ch.status       <= (err_q == StOk) ? StSyntax : err_q;
            end
            optop_q <= CntW'(1);
            vtop_q  <= '0;
            err_q   <= StOk;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // in S_END, capture the top operand, which is the result when one operand remains
      if (state_q == S_END) res_q <= v_rdata;
    end
  end
endmodule
